/* rtl/sqrt_profile_position_planner_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the position planner
// Shared helpers that wrap concurrent assertions on clock and reset.
// ---------------------------------------------------------------------------
`ifndef SQRT_PROFILE_POSITION_PLANNER_DEFINES_SVH
`define SQRT_PROFILE_POSITION_PLANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/spp_pkg.sv */
// ---------------------------------------------------------------------------
// Position planner package
// Widths, register map, command and status types shared by the modules.
// ---------------------------------------------------------------------------
package spp_pkg;

   // Fixed point layout.
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32 + FRAC_BITS;
   localparam int ERR_W     = POS_W + 1;
   localparam int VEL_W     = 40;
   localparam int VEL_FRAC  = 8;

   // Shared multiplier and square root unit sizes.
   localparam int MUL_A_W    = 50;
   localparam int MUL_B_W    = 40;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS  = MUL_B_W / 2;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
   localparam int LHS_W      = 74;
   localparam int ROOT_W     = LHS_W / 2;
   localparam int SQRT_CNT_W = $clog2(ROOT_W);
   localparam int DES_W      = ROOT_W + 1;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_MAX_SPEED      = 2'd0;
   localparam logic [1:0] REG_SMOOTHING_GAIN = 2'd1;
   localparam logic [1:0] REG_TICK_PERIOD    = 2'd2;
   localparam logic [23:0] MAX_SPEED_RESET   = 24'd100000;
   localparam logic [16:0] GAIN_RESET        = 17'd6554;
   localparam logic [31:0] TICK_RESET        = 32'd4294967;

   typedef struct packed {
      logic [23:0] max_speed;
      logic [16:0] smoothing_gain;
      logic [31:0] tick_period;
   } cfg_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE, OP_ENABLE, OP_DISABLE, OP_SNAP_GOAL, OP_KEEP_P1, OP_SMOOTH_ADD,
      OP_SETTLE, OP_KEEP_LHS, OP_PICK_FAST, OP_PICK_ROOT, OP_SPEED, OP_MOVE
   } op_type;

   // Operand selection for the shared multiplier.
   typedef enum logic [2:0] {
      MS_GAIN_HI, MS_GAIN_LO, MS_LHS, MS_RHS, MS_DV, MS_STEP
   } mul_sel_type;

   typedef struct packed {
      logic        load_in;
      op_type      op;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        sqrt_start;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic err_small;
      logic pe_small;
      logic fast;
      logic mul_busy;
      logic mul_done;
      logic sqrt_done;
   } stat_type;

endpackage

/* rtl/spp_mul.sv */
// ---------------------------------------------------------------------------
// Position planner multiplier
// Unsigned shift-add multiplier retiring two multiplier bits per cycle.
// ---------------------------------------------------------------------------
module spp_mul import spp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] product,
   output logic               busy,
   output logic               done
);

   logic [MUL_P_W-1:0]   a_ff, a_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [MUL_P_W-1:0]   acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_P_W-1:0]   partial;

   // Two partial products for the low multiplier bits.
   assign partial = (b_ff[0] ? a_ff : '0) + (b_ff[1] ? {a_ff[MUL_P_W-2:0], 1'b0} : '0);

   // Next-state logic for the iteration.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = MUL_P_W'(a);
         b_in     = b;
         acc_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + partial;
         a_in   = {a_ff[MUL_P_W-3:0], 2'b00};
         b_in   = {2'b00, b_ff[MUL_B_W-1:2]};
         if (count_ff == MUL_CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign busy    = busy_ff;
   assign done    = done_ff;

endmodule

/* rtl/spp_sqrt.sv */
// ---------------------------------------------------------------------------
// Position planner square root
// Digit-by-digit floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module spp_sqrt import spp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LHS_W-1:0]  x,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   logic [LHS_W-1:0]      x_ff, x_in;
   logic [ROOT_W+2:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SQRT_CNT_W-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_W+2:0]     shifted;
   logic [ROOT_W+2:0]     trial;

   // Bring down the next two bits and try the next root bit.
   assign shifted = {rem_ff[ROOT_W:0], x_ff[LHS_W-1:LHS_W-2]};
   assign trial   = {1'b0, root_ff, 2'b01};

   always_comb begin
      x_in     = x_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         x_in     = x;
         rem_in   = '0;
         root_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[LHS_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (count_ff == SQRT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* rtl/spp_datapath.sv */
// ---------------------------------------------------------------------------
// Position planner datapath
// Planner state, operand selection, shared arithmetic units and result.
// ---------------------------------------------------------------------------
module spp_datapath import spp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [63:0] in_data,
   input  logic        in_enable,
   output logic [31:0] out_position,
   output logic        out_settled
);

   localparam logic [ERR_W-1:0]   ONE      = ERR_W'(64'd1 << FRAC_BITS);
   localparam logic [16:0]        GAIN_ONE = 17'(64'd1 << 16);
   localparam logic [VEL_W+1:0]   VLIM     = (VEL_W+2)'((64'd1 << (VEL_W - 1)) - 1);
   localparam logic [VEL_W+1:0]   VLIM_NEG = ~VLIM + 1'b1;
   localparam logic [POS_W+1:0]   PMAX     = (POS_W+2)'((64'd1 << (POS_W - 1)) - 1);
   localparam logic [POS_W+1:0]   PMIN     = ~PMAX;

   // Truncate a position toward zero to whole counts.
   function automatic logic [31:0] to_count(input logic [POS_W-1:0] q);
      logic [POS_W-1:0] m;
      logic [31:0]      c;
      m = q[POS_W-1] ? (~q + 1'b1) : q;
      c = m[POS_W-1:FRAC_BITS];
      return q[POS_W-1] ? (~c + 1'b1) : c;
   endfunction

   logic [31:0]      meas_ff, goal_ff;
   logic             enable_ff;
   logic [POS_W-1:0] sg_ff, pp_ff;
   logic [VEL_W-1:0] v_ff;
   logic             motion_ff;
   logic [MUL_A_W-1:0] p1_ff;
   logic [LHS_W-1:0] lhs_ff;
   logic [DES_W-1:0] desired_ff;
   logic [31:0]      res_pos_ff, out_pos_ff;
   logic             res_settled_ff, out_settled_ff;

   logic [POS_W-1:0]   meas_q, goal_q;
   logic [ERR_W-1:0]   err, err_mag, pe, pe_mag;
   logic               err_neg, pe_neg, v_neg;
   logic [VEL_W-1:0]   v_mag;
   logic [16:0]        gain_eff;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   logic               mul_busy, mul_done, sqrt_done;
   logic [ROOT_W-1:0]  root;
   logic [MUL_A_W-1:0] smooth_step;
   logic [MUL_A_W-1:0] sg_sum;
   logic [VEL_W+1:0]   des_s, v_s, ve, ve_mag, dv_x, v_step, v_pick, v_new;
   logic [46:0]        pos_step;
   logic [POS_W+1:0]   pn, pn_clamp;

   // Errors between goal, smoothed goal and planned position.
   assign meas_q  = {meas_ff, {FRAC_BITS{1'b0}}};
   assign goal_q  = {goal_ff, {FRAC_BITS{1'b0}}};
   assign err     = {goal_q[POS_W-1], goal_q} - {sg_ff[POS_W-1], sg_ff};
   assign err_neg = err[ERR_W-1];
   assign err_mag = err_neg ? (~err + 1'b1) : err;
   assign pe      = {sg_ff[POS_W-1], sg_ff} - {pp_ff[POS_W-1], pp_ff};
   assign pe_neg  = pe[ERR_W-1];
   assign pe_mag  = pe_neg ? (~pe + 1'b1) : pe;
   assign v_neg   = v_ff[VEL_W-1];
   assign v_mag   = v_neg ? (~v_ff + 1'b1) : v_ff;
   assign gain_eff = (cfg.smoothing_gain > GAIN_ONE) ? GAIN_ONE : cfg.smoothing_gain;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_sel)
         MS_GAIN_HI: begin
            mul_a = MUL_A_W'(err_mag[ERR_W-1:16]);
            mul_b = MUL_B_W'(gain_eff);
         end
         MS_GAIN_LO: begin
            mul_a = MUL_A_W'(err_mag[15:0]);
            mul_b = MUL_B_W'(gain_eff);
         end
         MS_LHS: begin
            mul_a = MUL_A_W'(pe_mag);
            mul_b = MUL_B_W'({cfg.max_speed, 1'b0});
         end
         MS_RHS: begin
            mul_a = MUL_A_W'(v_mag);
            mul_b = v_mag;
         end
         MS_DV: begin
            mul_a = MUL_A_W'(cfg.tick_period);
            mul_b = MUL_B_W'(cfg.max_speed);
         end
         MS_STEP: begin
            mul_a = MUL_A_W'(v_mag);
            mul_b = MUL_B_W'(cfg.tick_period);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   spp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod),
      .busy    (mul_busy),
      .done    (mul_done)
   );

   spp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .x     (lhs_ff),
      .root  (root),
      .done  (sqrt_done)
   );

   // Smoothing step from the two gain products.
   assign smooth_step = p1_ff + MUL_A_W'(prod[31:16]);
   assign sg_sum = err_neg ? ({{2{sg_ff[POS_W-1]}}, sg_ff} - smooth_step)
                           : ({{2{sg_ff[POS_W-1]}}, sg_ff} + smooth_step);

   // Speed update limited by the per-tick change, then clamped.
   assign des_s  = pe_neg ? (~(VEL_W+2)'(desired_ff) + 1'b1) : (VEL_W+2)'(desired_ff);
   assign v_s    = {{2{v_ff[VEL_W-1]}}, v_ff};
   assign ve     = des_s - v_s;
   assign ve_mag = ve[VEL_W+1] ? (~ve + 1'b1) : ve;
   assign dv_x   = (VEL_W+2)'(prod[55:24]);
   assign v_step = ve[VEL_W+1] ? (v_s - dv_x) : (v_s + dv_x);
   assign v_pick = (ve_mag > dv_x) ? v_step : des_s;
   always_comb begin
      priority if ($signed(v_pick) > $signed(VLIM)) begin
         v_new = VLIM;
      end else if ($signed(v_pick) < $signed(VLIM_NEG)) begin
         v_new = VLIM_NEG;
      end else begin
         v_new = v_pick;
      end
   end

   // Position step and clamp to the count range.
   assign pos_step = prod[70:24];
   assign pn = v_neg ? ({{2{pp_ff[POS_W-1]}}, pp_ff} - (POS_W+2)'(pos_step))
                     : ({{2{pp_ff[POS_W-1]}}, pp_ff} + (POS_W+2)'(pos_step));
   always_comb begin
      priority if ($signed(pn) > $signed(PMAX)) begin
         pn_clamp = PMAX;
      end else if ($signed(pn) < $signed(PMIN)) begin
         pn_clamp = PMIN;
      end else begin
         pn_clamp = pn;
      end
   end

   // Planner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff     <= '0;
         pp_ff     <= '0;
         v_ff      <= '0;
         motion_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_ENABLE: begin
               if (!motion_ff) begin
                  sg_ff     <= meas_q;
                  pp_ff     <= meas_q;
                  v_ff      <= '0;
                  motion_ff <= 1'b1;
               end
            end
            OP_DISABLE: begin
               motion_ff <= 1'b0;
               v_ff      <= '0;
            end
            OP_SNAP_GOAL:  sg_ff <= goal_q;
            OP_SMOOTH_ADD: sg_ff <= sg_sum[POS_W-1:0];
            OP_SETTLE: begin
               pp_ff <= sg_ff;
               v_ff  <= '0;
            end
            OP_SPEED: v_ff  <= v_new[VEL_W-1:0];
            OP_MOVE:  pp_ff <= pn_clamp[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // Operands, intermediate results and the result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         meas_ff   <= in_data[31:0];
         goal_ff   <= in_data[63:32];
         enable_ff <= in_enable;
      end
      unique case (cmd.op)
         OP_KEEP_P1:   p1_ff      <= prod[MUL_A_W-1:0];
         OP_KEEP_LHS:  lhs_ff     <= prod[LHS_W-1:0];
         OP_PICK_FAST: desired_ff <= DES_W'({cfg.max_speed, {VEL_FRAC{1'b0}}});
         OP_PICK_ROOT: desired_ff <= DES_W'(root);
         OP_DISABLE: begin
            res_pos_ff     <= meas_ff;
            res_settled_ff <= 1'b0;
         end
         OP_SETTLE: begin
            res_pos_ff     <= to_count(sg_ff);
            res_settled_ff <= 1'b1;
         end
         OP_MOVE: begin
            res_pos_ff     <= to_count(pn_clamp[POS_W-1:0]);
            res_settled_ff <= 1'b0;
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         out_pos_ff     <= res_pos_ff;
         out_settled_ff <= res_settled_ff;
      end
   end

   // Status back to the controller.
   assign stat.enable    = enable_ff;
   assign stat.err_small = (err_mag <= ONE);
   assign stat.pe_small  = (pe_mag < ONE);
   assign stat.fast      = ({4'b0000, lhs_ff} > prod[77:0]);
   assign stat.mul_busy  = mul_busy;
   assign stat.mul_done  = mul_done;
   assign stat.sqrt_done = sqrt_done;

   assign out_position = out_pos_ff;
   assign out_settled  = out_settled_ff;

endmodule

/* rtl/spp_ctrl.sv */
// ---------------------------------------------------------------------------
// Position planner controller
// Sequences one tick through smoothing, planning and the output register.
// ---------------------------------------------------------------------------
module spp_ctrl import spp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   input  logic     in_valid,
   output logic     in_ready,
   output logic     out_valid,
   input  logic     out_ready,
   output cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_START   = 13'b0000000000010,
      S_SMOOTH  = 13'b0000000000100,
      S_GAIN_HI = 13'b0000000001000,
      S_GAIN_LO = 13'b0000000010000,
      S_PLAN    = 13'b0000000100000,
      S_LHS     = 13'b0000001000000,
      S_RHS     = 13'b0000010000000,
      S_ROOT    = 13'b0000100000000,
      S_DV      = 13'b0001000000000,
      S_ADVANCE = 13'b0010000000000,
      S_STEP    = 13'b0100000000000,
      S_OUT     = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd.load_in    = 1'b0;
      cmd.op         = OP_NONE;
      cmd.mul_start  = 1'b0;
      cmd.mul_sel    = MS_GAIN_HI;
      cmd.sqrt_start = 1'b0;
      cmd.out_load   = 1'b0;
      in_ready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (!stat.enable) begin
               cmd.op   = OP_DISABLE;
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_ENABLE;
               state_in = S_SMOOTH;
            end
         end
         S_SMOOTH: begin
            if (stat.err_small) begin
               cmd.op   = OP_SNAP_GOAL;
               state_in = S_PLAN;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_GAIN_HI;
               state_in      = S_GAIN_HI;
            end
         end
         S_GAIN_HI: begin
            if (stat.mul_done) begin
               cmd.op        = OP_KEEP_P1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_GAIN_LO;
               state_in      = S_GAIN_LO;
            end
         end
         S_GAIN_LO: begin
            if (stat.mul_done) begin
               cmd.op   = OP_SMOOTH_ADD;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            if (stat.pe_small) begin
               cmd.op   = OP_SETTLE;
               state_in = S_OUT;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_LHS;
               state_in      = S_LHS;
            end
         end
         S_LHS: begin
            if (stat.mul_done) begin
               cmd.op        = OP_KEEP_LHS;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_RHS;
               state_in      = S_RHS;
            end
         end
         S_RHS: begin
            if (stat.mul_done) begin
               if (stat.fast) begin
                  cmd.op        = OP_PICK_FAST;
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel   = MS_DV;
                  state_in      = S_DV;
               end else begin
                  cmd.sqrt_start = 1'b1;
                  state_in       = S_ROOT;
               end
            end
         end
         S_ROOT: begin
            if (stat.sqrt_done) begin
               cmd.op        = OP_PICK_ROOT;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_DV;
               state_in      = S_DV;
            end
         end
         S_DV: begin
            if (stat.mul_done) begin
               cmd.op   = OP_SPEED;
               state_in = S_ADVANCE;
            end
         end
         S_ADVANCE: begin
            // The step product needs the speed that was just written.
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_STEP;
            state_in      = S_STEP;
         end
         S_STEP: begin
            if (stat.mul_done) begin
               cmd.op   = OP_MOVE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!valid_ff || out_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid flag of the output register.
   always_comb begin
      priority if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;

endmodule

/* rtl/sqrt_profile_position_planner.sv */
// ---------------------------------------------------------------------------
// Square root profile position planner
// Plans one commanded servo position per control tick.
// ---------------------------------------------------------------------------
// Usage: each control tick sends one item on the req channel (measured
// position, goal position, drive enable in tuser) and receives one item on
// the rsp channel (command position, settled flag in tuser).
// A disabled tick goes straight to the output step, and a tick that
// snaps and settles runs no products. Smoothing adds two products. A
// moving tick adds four more products, plus the square root when braking.
// The result becomes valid in the same cycle as the next item can be
// accepted. All products share one multiplier that retires two bits per
// cycle, and the square root retires one bit per cycle. One item is planned
// at a time.
// The next item is accepted as soon as the planner is idle, even while the
// previous result still waits in the output register; a stalled receiver
// holds the planner in its final step until that register frees up.
// Reset clears the planner state and restores the register defaults.
// Registers: 0 max_speed, 4 smoothing_gain, 8 tick_period.
// ---------------------------------------------------------------------------
`include "sqrt_profile_position_planner_defines.svh"

module sqrt_profile_position_planner import spp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // tdata: measured_position [31:0], goal_position [63:32]
   input  logic [63:0]           req_tdata,
   // tuser: drive_enable [0]
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: command_position [31:0]
   output logic [31:0]           rsp_tdata,
   // tuser: settled [0]
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;
   logic     csr_write;
   logic [1:0] csr_index;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MAX_SPEED:      cfg_in.max_speed      = pwdata[23:0];
            REG_SMOOTHING_GAIN: cfg_in.smoothing_gain = pwdata[16:0];
            REG_TICK_PERIOD:    cfg_in.tick_period    = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed      <= MAX_SPEED_RESET;
         cfg_ff.smoothing_gain <= GAIN_RESET;
         cfg_ff.tick_period    <= TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_index)
         REG_MAX_SPEED:      prdata = 32'(cfg_ff.max_speed);
         REG_SMOOTHING_GAIN: prdata = 32'(cfg_ff.smoothing_gain);
         REG_TICK_PERIOD:    prdata = cfg_ff.tick_period;
         default:            prdata = '0;
      endcase
   end

   spp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd)
   );

   spp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .stat         (stat),
      .in_data      (req_tdata),
      .in_enable    (req_tuser),
      .out_position (rsp_tdata),
      .out_settled  (rsp_tuser)
   );

   // One item at a time: after an accept, the planner is busy.
   `SPP_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready, "item accepted while busy")
   // A new result never overwrites one that is still waiting.
   `SPP_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(rsp_tvalid && !rsp_tready), "result lost")
   // The shared multiplier is never restarted in the middle of a product.
   `SPP_ASSERT_SAME(a_mul_free, cmd.mul_start, !stat.mul_busy, "multiplier restarted")

endmodule
